FILE: hw/rtl/ucs_pkg.sv
`default_nettype none
package ucs_pkg;

    localparam logic [2:0] COMP_PROTOCOL = 3'd0;
    localparam logic [2:0] COMP_HOST     = 3'd1;
    localparam logic [2:0] COMP_PORT     = 3'd2;
    localparam logic [2:0] COMP_PATH     = 3'd3;
    localparam logic [2:0] COMP_SEARCH   = 3'd4;
    localparam logic [2:0] COMP_HASH     = 3'd5;
    localparam logic [2:0] COMP_END      = 3'd6;

    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_NL    = 8'h0A;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_SLASH = 8'h2F;
    localparam logic [7:0] CHR_QUERY = 8'h3F;
    localparam logic [7:0] CHR_HASH  = 8'h23;

    localparam int HTTPS_LEN = 5;
    localparam logic [2:0] HTTPS_LEN_V = 3'd5;
    localparam logic [2:0] PROTO_LEN_MAX = 3'd7;
    localparam logic [1:0] SKIP_AFTER_PROTO = 2'd2;

    localparam logic [7:0] HTTPS_TEXT [HTTPS_LEN] = '{8'h68, 8'h74, 8'h74, 8'h70, 8'h73};

    typedef struct packed {
        logic [2:0] component;
        logic [7:0] out_byte;
        logic       is_https;
        logic       port_given;
    } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ucs_in_if.sv
`default_nettype none
interface ucs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ucs_out_if.sv
`default_nettype none
interface ucs_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] component;
    logic [7:0] out_byte;
    logic       is_https;
    logic       port_given;

    modport source (output valid, output component, output out_byte, output is_https,
                    output port_given, input ready);
    modport sink (input valid, input component, input out_byte, input is_https,
                  input port_given, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/url_component_splitter_core.sv
// an accepted byte passes the input register, then the result buffer
// throughput: one byte per cycle while the spare entry is empty; phase update is combinational
// bytes that are skipped or are consumed delimiters give no result
// a two-entry result buffer takes one more result after the output stalls, then holds input
// asynchronous active-low reset empties both stages and returns to the protocol phase
`default_nettype none
module url_component_splitter_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ucs_in_if.sink     text,
    ucs_out_if.source  result
);
    import ucs_pkg::*;

    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       can_push;
    logic       proc_fire;
    logic       emit;
    result_t    step_result;

    assign proc_fire  = in_vld_reg && can_push;
    assign text.ready = !in_vld_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (text.ready)
        begin
            in_vld_reg <= text.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            in_byte_reg <= text.text_byte;
        end
    end

    ucs_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (proc_fire),
        .text_byte (in_byte_reg),
        .emit      (emit),
        .result    (step_result)
    );

    ucs_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (proc_fire && emit),
        .push_data (step_result),
        .can_push  (can_push),
        .result    (result)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/ucs_tracker.sv
`default_nettype none
module ucs_tracker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  wire logic [7:0]      text_byte,
    output logic                 emit,
    output ucs_pkg::result_t     result
);
    import ucs_pkg::*;

    logic [2:0] phase_reg, phase_next;
    logic [1:0] skip_left_reg, skip_left_next;
    logic [2:0] proto_len_reg, proto_len_next;
    logic       https_match_reg, https_match_next;
    logic       port_seen_reg, port_seen_next;
    logic       term;

    assign term = (text_byte == CHR_NL) || (text_byte == CHR_NUL);

    always_comb
    begin
        phase_next       = phase_reg;
        skip_left_next   = skip_left_reg;
        proto_len_next   = proto_len_reg;
        https_match_next = https_match_reg;
        port_seen_next   = port_seen_reg;
        emit             = 1'b0;
        result           = '0;
        if (term)
        begin
            emit              = 1'b1;
            result.component  = COMP_END;
            result.is_https   = https_match_reg && (proto_len_reg == HTTPS_LEN_V);
            result.port_given = port_seen_reg;
            phase_next        = COMP_PROTOCOL;
            skip_left_next    = 2'd0;
            proto_len_next    = 3'd0;
            https_match_next  = 1'b1;
            port_seen_next    = 1'b0;
        end
        else if (skip_left_reg != 2'd0)
        begin
            skip_left_next = skip_left_reg - 2'd1;
        end
        else
        begin
            result.out_byte = text_byte;
            unique case (phase_reg)
                COMP_PROTOCOL:
                begin
                    if (text_byte == CHR_COLON)
                    begin
                        phase_next     = COMP_HOST;
                        skip_left_next = SKIP_AFTER_PROTO;
                    end
                    else
                    begin
                        if (proto_len_reg >= HTTPS_LEN_V ||
                            HTTPS_TEXT[proto_len_reg] != text_byte)
                            https_match_next = 1'b0;
                        if (proto_len_reg != PROTO_LEN_MAX)
                            proto_len_next = proto_len_reg + 3'd1;
                        emit             = 1'b1;
                        result.component = COMP_PROTOCOL;
                    end
                end
                COMP_HOST:
                begin
                    if (text_byte == CHR_COLON)
                    begin
                        phase_next     = COMP_PORT;
                        port_seen_next = 1'b1;
                    end
                    else if (text_byte == CHR_SLASH)
                        phase_next = COMP_PATH;
                    else if (text_byte == CHR_QUERY)
                        phase_next = COMP_SEARCH;
                    else if (text_byte == CHR_HASH)
                        phase_next = COMP_HASH;
                    else
                    begin
                        emit             = 1'b1;
                        result.component = COMP_HOST;
                    end
                end
                COMP_PORT:
                begin
                    if (text_byte == CHR_SLASH)
                        phase_next = COMP_PATH;
                    else if (text_byte == CHR_QUERY)
                        phase_next = COMP_SEARCH;
                    else if (text_byte == CHR_HASH)
                        phase_next = COMP_HASH;
                    else
                    begin
                        emit             = 1'b1;
                        result.component = COMP_PORT;
                    end
                end
                COMP_PATH:
                begin
                    if (text_byte == CHR_QUERY)
                        phase_next = COMP_SEARCH;
                    else if (text_byte == CHR_HASH)
                        phase_next = COMP_HASH;
                    else
                    begin
                        emit             = 1'b1;
                        result.component = COMP_PATH;
                    end
                end
                COMP_SEARCH:
                begin
                    if (text_byte == CHR_HASH)
                        phase_next = COMP_HASH;
                    else
                    begin
                        emit             = 1'b1;
                        result.component = COMP_SEARCH;
                    end
                end
                default:
                begin
                    emit             = 1'b1;
                    result.component = COMP_HASH;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= COMP_PROTOCOL;
            skip_left_reg   <= 2'd0;
            proto_len_reg   <= 3'd0;
            https_match_reg <= 1'b1;
            port_seen_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg       <= phase_next;
            skip_left_reg   <= skip_left_next;
            proto_len_reg   <= proto_len_next;
            https_match_reg <= https_match_next;
            port_seen_reg   <= port_seen_next;
        end
    end

    // the skip window only opens on the way into the host
    a_skip_in_host: assert property (@(posedge clk) disable iff (!rst_n)
        (skip_left_reg != 2'd0) |-> (phase_reg == COMP_HOST))
        else $error("skip pending outside host phase");

    // a terminator leaves the tracker in its reset state
    a_term_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && term) |=> (phase_reg == COMP_PROTOCOL && proto_len_reg == 3'd0 &&
                            https_match_reg && !port_seen_reg))
        else $error("state not cleared after end record");

    // port flag only set once the host is behind us
    a_port_flag: assert property (@(posedge clk) disable iff (!rst_n)
        port_seen_reg |-> (phase_reg != COMP_PROTOCOL && phase_reg != COMP_HOST))
        else $error("port flag set before port phase");

endmodule
`default_nettype wire

FILE: hw/rtl/ucs_out_stage.sv
`default_nettype none
module ucs_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ucs_pkg::result_t  push_data,
    output logic                   can_push,
    ucs_out_if.source              result
);
    import ucs_pkg::*;

    result_t head_reg;
    result_t spare_reg;
    logic    head_vld_reg;
    logic    spare_vld_reg;
    logic    head_free;

    assign can_push  = !spare_vld_reg;
    assign head_free = !head_vld_reg || result.ready;

    assign result.valid      = head_vld_reg;
    assign result.component  = head_reg.component;
    assign result.out_byte   = head_reg.out_byte;
    assign result.is_https   = head_reg.is_https;
    assign result.port_given = head_reg.port_given;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg  <= 1'b0;
            spare_vld_reg <= 1'b0;
        end
        else if (head_free)
        begin
            head_vld_reg  <= spare_vld_reg || push;
            spare_vld_reg <= 1'b0;
        end
        else if (push)
        begin
            spare_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_free)
        begin
            head_reg <= spare_vld_reg ? spare_reg : push_data;
        end
        else if (push)
        begin
            spare_reg <= push_data;
        end
    end

    a_spare_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        spare_vld_reg |-> head_vld_reg)
        else $error("spare item held with empty head");

    // spare only fills while the head is stalled
    a_spare_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(spare_vld_reg) |-> $past(head_vld_reg && !result.ready && push))
        else $error("spare filled without a stall");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (spare_vld_reg && !result.ready) |=> spare_vld_reg && $stable(spare_reg))
        else $error("spare item lost under stall");

endmodule
`default_nettype wire
